// ===== sv/msgq_pkg.sv =====
// Shared types and codes for the message ring queue.
// Status codes, request kinds and the result metadata struct.
// No dependencies.
package msgq_pkg;

   // Fixed field widths
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 3;

   // Request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_READ_BYTE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_READ_EMPTY_MSG = 3'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_WRITE_STORED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_WRITE_REFUSED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_WRITE_TRUNC    = 3'd5;

   // Metadata of the item held in the result register
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
      logic                last;
      logic                from_ram;   // byte comes from the store read port
   } rsp_meta_type;

endpackage

// ===== sv/msgq_ram.sv =====
// Byte store of the message ring queue: one write port, one read port.
// Read data is registered and held while no read is issued.
// No package dependencies.
module msgq_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/msgq_ctrl.sv =====
// Control of the message ring queue: write path, read sequencer, slot lengths
// and the result register. Drives the byte store in msgq_ram.
// Depends on msgq_pkg.
module msgq_ctrl #(
   parameter int SLOT_COUNT = 4,
   parameter int SLOT_BYTES = 64,
   parameter int ADDR_W     = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [7:0]            req_byte,
   input  logic                  req_present,
   input  logic                  req_eom,
   // result side
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output msgq_pkg::rsp_meta_type rsp_meta,
   // byte store
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [7:0]            wr_data,
   output logic                  rd_en,
   output logic [ADDR_W-1:0]     rd_addr
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int USED_W = $clog2(SLOT_COUNT + 1);
   localparam int POS_W  = $clog2(SLOT_BYTES + 1);

   // Sequencer states
   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_READ = 1'b1;

   // Write modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_OPEN   = 2'd1;
   localparam logic [1:0] MODE_TRUNC  = 2'd2;
   localparam logic [1:0] MODE_REFUSE = 2'd3;

   logic                  state_ff, state_in;
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [POS_W-1:0]      wpos_ff, wpos_in;
   logic [1:0]            mode_ff, mode_in;
   logic [POS_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [POS_W-1:0]      rd_len_ff, rd_len_in;
   logic [POS_W-1:0]      len_ff [SLOT_COUNT];
   logic [POS_W-1:0]      len_in [SLOT_COUNT];
   logic                  rsp_valid_ff, rsp_valid_in;
   msgq_pkg::rsp_meta_type meta_ff, meta_in;

   logic                  out_free;
   logic                  accept;
   logic [POS_W-1:0]      head_len;
   logic [SLOT_W-1:0]     head_next;
   logic [SLOT_W-1:0]     tail_next;
   logic [1:0]            mode_cur;
   logic [POS_W-1:0]      pos_cur;
   logic                  byte_fits;
   logic                  byte_store;
   logic                  byte_drop;
   logic [1:0]            mode_upd;
   logic [POS_W-1:0]      pos_upd;
   logic [POS_W-1:0]      rd_pos;
   logic                  rd_last;

   // Handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Ring pointers
   assign head_len  = len_ff[head_ff];
   assign head_next = (head_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_ff + SLOT_W'(1);
   assign tail_next = (tail_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail_ff + SLOT_W'(1);

   // Write path: a write item in idle mode opens or refuses a message
   assign mode_cur   = (mode_ff != MODE_IDLE) ? mode_ff :
                       (used_ff == USED_W'(SLOT_COUNT)) ? MODE_REFUSE : MODE_OPEN;
   assign pos_cur    = (mode_ff == MODE_IDLE) ? '0 : wpos_ff;
   assign byte_fits  = pos_cur < POS_W'(SLOT_BYTES);
   assign byte_store = req_present && (mode_cur != MODE_REFUSE) && byte_fits;
   assign byte_drop  = req_present && (mode_cur != MODE_REFUSE) && !byte_fits;
   assign mode_upd   = byte_drop ? MODE_TRUNC : mode_cur;
   assign pos_upd    = byte_store ? pos_cur + POS_W'(1) : pos_cur;

   // Store addresses
   assign wr_addr = ADDR_W'(tail_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos_cur);
   assign wr_data = req_byte;
   assign rd_pos  = (state_ff == FSM_IDLE) ? '0 : rd_idx_ff;
   assign rd_addr = ADDR_W'(head_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rd_pos);
   assign rd_last = (rd_idx_ff + POS_W'(1)) == rd_len_ff;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      used_in      = used_ff;
      wpos_in      = wpos_ff;
      mode_in      = mode_ff;
      rd_idx_in    = rd_idx_ff;
      rd_len_in    = rd_len_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      meta_in      = meta_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (accept && (req_kind == msgq_pkg::REQ_READ)) begin
               rsp_valid_in = 1'b1;
               if (used_ff == '0) begin
                  meta_in = '{msgq_pkg::ST_QUEUE_EMPTY, '0, 1'b1, 1'b0};
               end else if (head_len == '0) begin
                  meta_in          = '{msgq_pkg::ST_READ_EMPTY_MSG, '0, 1'b1, 1'b0};
                  len_in[head_ff]  = '0;
                  head_in          = head_next;
                  used_in          = used_ff - USED_W'(1);
               end else begin
                  // first byte goes out now, the rest in the read state
                  rd_en   = 1'b1;
                  meta_in = '{msgq_pkg::ST_READ_BYTE,
                              msgq_pkg::LEN_W'(head_len),
                              head_len == POS_W'(1), 1'b1};
                  if (head_len == POS_W'(1)) begin
                     len_in[head_ff] = '0;
                     head_in         = head_next;
                     used_in         = used_ff - USED_W'(1);
                  end else begin
                     state_in  = FSM_READ;
                     rd_idx_in = POS_W'(1);
                     rd_len_in = head_len;
                  end
               end
            end else if (accept) begin
               wr_en = byte_store;
               if (req_eom) begin
                  rsp_valid_in = 1'b1;
                  if (mode_upd == MODE_REFUSE) begin
                     meta_in = '{msgq_pkg::ST_WRITE_REFUSED, '0, 1'b1, 1'b0};
                  end else begin
                     meta_in = '{(mode_upd == MODE_TRUNC) ? msgq_pkg::ST_WRITE_TRUNC
                                                          : msgq_pkg::ST_WRITE_STORED,
                                 msgq_pkg::LEN_W'(pos_upd), 1'b1, 1'b0};
                     len_in[tail_ff] = pos_upd;
                     tail_in         = tail_next;
                     used_in         = used_ff + USED_W'(1);
                  end
                  mode_in = MODE_IDLE;
                  wpos_in = '0;
               end else begin
                  mode_in = mode_upd;
                  wpos_in = pos_upd;
               end
            end
         end
         FSM_READ: begin
            // one byte per cycle while the result register can take it
            if (out_free) begin
               rd_en        = 1'b1;
               rsp_valid_in = 1'b1;
               meta_in      = '{msgq_pkg::ST_READ_BYTE,
                                msgq_pkg::LEN_W'(rd_len_ff), rd_last, 1'b1};
               rd_idx_in    = rd_idx_ff + POS_W'(1);
               if (rd_last) begin
                  len_in[head_ff] = '0;
                  head_in         = head_next;
                  used_in         = used_ff - USED_W'(1);
                  state_in        = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         wpos_ff      <= '0;
         mode_ff      <= MODE_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         used_ff      <= used_in;
         wpos_ff      <= wpos_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      rd_len_ff <= rd_len_in;
      meta_ff   <= meta_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_meta  = meta_ff;

endmodule

// ===== sv/message_ring_queue_unit.sv =====
// Message ring queue: an accepted item gives its first result in the next cycle.
// A read of an L-byte message (L > 0) streams L results, one per cycle while the
// result channel is ready, paced by the single read port of the byte store, and
// holds off new items until its last byte is issued. Synchronous active-high reset
// clears pointers, counts, slot lengths and write mode; the byte store is not cleared.
// Depends on msgq_pkg, msgq_ctrl and msgq_ram.
module message_ring_queue_unit #(
   parameter int SLOT_COUNT = 4,
   parameter int SLOT_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] byte_present, zero pad
   input  logic [0:0]  req_tuser,   // [0] req_type
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [14:8] msg_length, zero pad
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast    // last
);

   localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [7:0]             wr_data;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [7:0]             rd_data;
   msgq_pkg::rsp_meta_type meta;

   msgq_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_BYTES (SLOT_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser[0]),
      .req_byte    (req_tdata[7:0]),
      .req_present (req_tdata[8]),
      .req_eom     (req_tlast),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_meta    (meta),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   msgq_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result packing; the byte is zero unless it came from the store
   assign rsp_tdata = {1'b0, meta.length, meta.from_ram ? rd_data : 8'h00};
   assign rsp_tuser = meta.status;
   assign rsp_tlast = meta.last;

endmodule

// ===== sv/msgq_checker.sv =====
// Port-level checks on the result channel of the message ring queue,
// bound to message_ring_queue_unit. Depends on msgq_pkg.
module msgq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // Every result other than a read byte is a single last item with no byte
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != msgq_pkg::ST_READ_BYTE)
      |-> rsp_tlast && (rsp_tdata[7:0] == 8'h00))
      else $error("non-read result not single or carries a byte");

   // Empty answers and refusals report no length
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == msgq_pkg::ST_READ_EMPTY_MSG) ||
                     (rsp_tuser == msgq_pkg::ST_QUEUE_EMPTY) ||
                     (rsp_tuser == msgq_pkg::ST_WRITE_REFUSED))
      |-> rsp_tdata[14:8] == 7'd0)
      else $error("length on empty or refused result");

   // A read byte belongs to a message of non-zero length
   a_read_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == msgq_pkg::ST_READ_BYTE) |-> rsp_tdata[14:8] != 7'd0)
      else $error("read byte with zero length");

endmodule

bind message_ring_queue_unit msgq_checker u_msgq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
